// ----- hw/rtl/value_noise_ground_shade_assert.svh -----
// assertion macros for the ground shade block
`ifndef VALUE_NOISE_GROUND_SHADE_ASSERT_SVH
`define VALUE_NOISE_GROUND_SHADE_ASSERT_SVH

`ifndef SYNTHESIS
`define VNGS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VNGS_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VNGS_ASSERT(label, clk, rst_n, prop, msg)
`define VNGS_ASSERT_RST(label, clk, prop, msg)
`endif

`endif

// ----- hw/rtl/vngs_pkg.sv -----
// shared constants, types and helpers of the ground shade block
package vngs_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;

    localparam int PX_W     = COORD_BITS + 16;
    localparam int TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int ALPHA_W  = 8;
    localparam int CFG_W    = 32;
    localparam int OCT_LAT  = 8;
    localparam int PIPE_DEPTH = OCT_LAT + 5;

    localparam logic [31:0] HASH_MX = 32'd374761393;
    localparam logic [31:0] HASH_MY = 32'd668265263;
    localparam logic [31:0] HASH_MF = 32'd1274126177;

    localparam logic [FRAC_BITS:0]   ONE_F   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS+1:0] THREE_F = {2'b11, {FRAC_BITS{1'b0}}};
    localparam logic [16:0]          ONE_16  = 17'h10000;

    typedef enum logic [2:0] {
        REG_COARSE_FREQ = 3'd0,
        REG_FINE_FREQ   = 3'd1,
        REG_COARSE_SALT = 3'd2,
        REG_FINE_SALT   = 3'd3,
        REG_COARSE_WGT  = 3'd4,
        REG_THRESHOLD   = 3'd5,
        REG_INV_SPAN    = 3'd6,
        REG_MAX_ALPHA   = 3'd7
    } t_reg_idx;

    // q0.16 to q0.FRAC_BITS with truncation
    function automatic logic [FRAC_BITS-1:0] q16_to_frac(input logic [15:0] v);
        logic [FRAC_BITS+15:0] t;
        t = {v, {FRAC_BITS{1'b0}}};
        return t[FRAC_BITS+15:16];
    endfunction

    // q0.FRAC_BITS to q0.16 with truncation
    function automatic logic [15:0] frac_to_q16(input logic [FRAC_BITS-1:0] v);
        logic [FRAC_BITS+15:0] t;
        t = {v, 16'b0};
        return t[FRAC_BITS+15:FRAC_BITS];
    endfunction

endpackage

// ----- hw/rtl/vngs_octave.sv -----
// one octave of 2d value noise, eight register stages
module vngs_octave (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [vngs_pkg::COORD_BITS-1:0] i_cx,
    input  logic [vngs_pkg::COORD_BITS-1:0] i_cy,
    input  logic [15:0]                    i_freq,
    input  logic [31:0]                    i_salt,
    output logic [vngs_pkg::FRAC_BITS-1:0]  o_noise
);
    import vngs_pkg::*;

    logic [PX_W-1:0]        r_px, r_py;
    logic [31:0]            r_hx, r_hy;
    logic [FRAC_BITS-1:0]   r_fx2, r_fy2;
    logic [31:0]            r_h [4];
    logic [FRAC_BITS-1:0]   r_f2x, r_f2y, r_fx3, r_fy3;
    logic [31:0]            r_g [4];
    logic [FRAC_BITS:0]     r_sx, r_sy;
    logic [2*FRAC_BITS:0]   r_bp [4];
    logic [FRAC_BITS:0]     r_sy5, r_sy6;
    logic [FRAC_BITS-1:0]   r_ab, r_cd;
    logic [2*FRAC_BITS:0]   r_q0, r_q1;
    logic [FRAC_BITS-1:0]   r_noise;

    logic [COORD_BITS-1:0]  x0, y0;
    logic [31:0]            base;
    logic [31:0]            mixed [4];
    logic [FRAC_BITS-1:0]   cval [4];
    logic [2*FRAC_BITS-1:0] sq_x, sq_y;
    logic [2*FRAC_BITS+1:0] sm_x, sm_y;
    logic [2*FRAC_BITS+1:0] sum_ab, sum_cd, sum_q;
    logic [FRAC_BITS:0]     nsx;

    always_comb begin
        x0   = r_px[PX_W-1:16];
        y0   = r_py[PX_W-1:16];
        base = r_hx + r_hy + i_salt;
        sq_x = r_fx2 * r_fx2;
        sq_y = r_fy2 * r_fy2;
        sm_x = r_f2x * (THREE_F - {1'b0, r_fx3, 1'b0});
        sm_y = r_f2y * (THREE_F - {1'b0, r_fy3, 1'b0});
        for (int i = 0; i < 4; i++) begin
            mixed[i] = r_h[i] ^ (r_h[i] >> 13);
            cval[i]  = q16_to_frac(r_g[i][15:0] ^ r_g[i][31:16]);
        end
        nsx    = ONE_F - r_sx;
        sum_ab = {1'b0, r_bp[0]} + {1'b0, r_bp[1]};
        sum_cd = {1'b0, r_bp[2]} + {1'b0, r_bp[3]};
        sum_q  = {1'b0, r_q0} + {1'b0, r_q1};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // lattice position
            r_px <= {{(PX_W-COORD_BITS){1'b0}}, i_cx} * {{(PX_W-16){1'b0}}, i_freq};
            r_py <= {{(PX_W-COORD_BITS){1'b0}}, i_cy} * {{(PX_W-16){1'b0}}, i_freq};
            // hash row and column terms, fractions
            r_hx  <= HASH_MX * {{(32-COORD_BITS){1'b0}}, x0};
            r_hy  <= HASH_MY * {{(32-COORD_BITS){1'b0}}, y0};
            r_fx2 <= q16_to_frac(r_px[15:0]);
            r_fy2 <= q16_to_frac(r_py[15:0]);
            // corner sums, fraction squares
            r_h[0] <= base;
            r_h[1] <= base + HASH_MX;
            r_h[2] <= base + HASH_MY;
            r_h[3] <= base + HASH_MX + HASH_MY;
            r_f2x  <= sq_x[2*FRAC_BITS-1:FRAC_BITS];
            r_f2y  <= sq_y[2*FRAC_BITS-1:FRAC_BITS];
            r_fx3  <= r_fx2;
            r_fy3  <= r_fy2;
            // hash finalize multiply, smoothstep
            for (int i = 0; i < 4; i++) begin
                r_g[i] <= mixed[i] * HASH_MF;
            end
            r_sx <= sm_x[2*FRAC_BITS:FRAC_BITS];
            r_sy <= sm_y[2*FRAC_BITS:FRAC_BITS];
            // horizontal blend products
            r_bp[0] <= cval[0] * nsx;
            r_bp[1] <= cval[1] * r_sx;
            r_bp[2] <= cval[2] * nsx;
            r_bp[3] <= cval[3] * r_sx;
            r_sy5   <= r_sy;
            r_ab    <= sum_ab[2*FRAC_BITS-1:FRAC_BITS];
            r_cd    <= sum_cd[2*FRAC_BITS-1:FRAC_BITS];
            r_sy6   <= r_sy5;
            // vertical blend
            r_q0    <= r_ab * (ONE_F - r_sy6);
            r_q1    <= r_cd * r_sy6;
            r_noise <= sum_q[2*FRAC_BITS-1:FRAC_BITS];
        end
    end

    assign o_noise = r_noise;

endmodule

// ----- hw/rtl/value_noise_ground_shade.sv -----
// top level: two-octave value noise shade alpha per ground cell
//
// input stream s_axis carries one cell per request: cell_x and cell_y in
// tdata, the grass flag in tuser. output stream m_axis carries one shade
// alpha per cell, in the same order. every cell gives exactly one result.
// the block is a 13-stage pipeline, and one cell is taken every cycle while
// the output is not stalled (throughput 1). the depth is set by the hash
// multiplies and the two bilinear blend steps of each octave (8 stages)
// plus the weighting, threshold ramp and alpha scaling (5 stages).
// the whole pipeline advances together; when the receiver holds
// m_axis_tready low with a result waiting, every stage holds and
// s_axis_tready drops, so nothing is lost or repeated. synchronous reset
// empties the pipeline and loads default register values. the user must
// write registers via i_cfg_* only while the pipeline is empty (unchecked).
module value_noise_ground_shade (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [2:0]                    i_cfg_index,
    input  logic [vngs_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [vngs_pkg::TDATA_W-1:0]  s_axis_tdata,  // cell_x, cell_y
    input  logic                          s_axis_tuser,  // is_grass
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [vngs_pkg::ALPHA_W-1:0]  m_axis_tdata   // shade_alpha
);
    import vngs_pkg::*;

`include "value_noise_ground_shade_assert.svh"

    logic [15:0] r_coarse_freq, r_fine_freq, r_inv_span;
    logic [31:0] r_coarse_salt, r_fine_salt;
    logic [16:0] r_coarse_wgt, r_threshold;
    logic [7:0]  r_max_alpha;

    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-2:0] r_grass;
    logic                  en;

    logic [FRAC_BITS-1:0]  noise_c, noise_f;
    logic [FRAC_BITS+16:0] r_wc, r_wf;
    logic [FRAC_BITS+17:0] wsum;
    logic [15:0]           n16;
    logic [16:0]           w;
    logic                  r_over, r_over3, r_over4;
    logic [15:0]           r_ex;
    logic [31:0]           r_kp;
    logic [16:0]           k;
    logic [24:0]           r_am;
    logic [ALPHA_W-1:0]    r_alpha;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coarse_freq <= 16'd2097;
            r_fine_freq   <= 16'd6423;
            r_coarse_salt <= 32'd7;
            r_fine_salt   <= 32'd23;
            r_coarse_wgt  <= 17'd43254;
            r_threshold   <= 17'd30147;
            r_inv_span    <= 16'd13653;
            r_max_alpha   <= 8'd78;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_COARSE_FREQ: r_coarse_freq <= i_cfg_data[15:0];
                REG_FINE_FREQ:   r_fine_freq   <= i_cfg_data[15:0];
                REG_COARSE_SALT: r_coarse_salt <= i_cfg_data[31:0];
                REG_FINE_SALT:   r_fine_salt   <= i_cfg_data[31:0];
                REG_COARSE_WGT:  r_coarse_wgt  <= i_cfg_data[16:0];
                REG_THRESHOLD:   r_threshold   <= i_cfg_data[16:0];
                REG_INV_SPAN:    r_inv_span    <= i_cfg_data[15:0];
                REG_MAX_ALPHA:   r_max_alpha   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign en            = !r_vld[PIPE_DEPTH-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[PIPE_DEPTH-1];
    assign m_axis_tdata  = r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_grass <= {r_grass[PIPE_DEPTH-3:0], s_axis_tuser};
        end
    end

    vngs_octave u_coarse (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_cx    (s_axis_tdata[COORD_BITS-1:0]),
        .i_cy    (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_freq  (r_coarse_freq),
        .i_salt  (r_coarse_salt),
        .o_noise (noise_c)
    );

    vngs_octave u_fine (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_cx    (s_axis_tdata[COORD_BITS-1:0]),
        .i_cy    (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_freq  (r_fine_freq),
        .i_salt  (r_fine_salt),
        .o_noise (noise_f)
    );

    always_comb begin
        w    = (r_coarse_wgt > ONE_16) ? ONE_16 : r_coarse_wgt;
        wsum = {1'b0, r_wc} + {1'b0, r_wf};
        n16  = frac_to_q16(wsum[FRAC_BITS+15:16]);
        k    = (r_kp[31:12] > 20'(ONE_16)) ? ONE_16 : r_kp[28:12];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // octave weighting
            r_wc    <= noise_c * w;
            r_wf    <= noise_f * (ONE_16 - w);
            // threshold
            r_over  <= {1'b0, n16} > r_threshold;
            r_ex    <= n16 - r_threshold[15:0];
            // ramp
            r_kp    <= r_ex * r_inv_span;
            r_over3 <= r_over;
            // alpha scaling
            r_am    <= r_max_alpha * k;
            r_over4 <= r_over3;
            r_alpha <= (r_over4 && r_grass[PIPE_DEPTH-2]) ? r_am[23:16] : '0;
        end
    end

    `VNGS_ASSERT(a_alpha_max, i_clk, i_rst_n,
        m_axis_tvalid |-> (m_axis_tdata <= r_max_alpha), "alpha above max_alpha")
    `VNGS_ASSERT(a_not_grass, i_clk, i_rst_n,
        (en && r_vld[PIPE_DEPTH-2] && !r_grass[PIPE_DEPTH-2]) |=> (m_axis_tdata == '0),
        "non-grass cell gave nonzero alpha")
    `VNGS_ASSERT(a_stall_hold, i_clk, i_rst_n,
        !en |=> $stable(r_vld), "pipeline moved while stalled")
    `VNGS_ASSERT_RST(a_reset_empty, i_clk,
        !i_rst_n |=> (!m_axis_tvalid && (r_vld == '0)), "pipeline not empty after reset")

endmodule

// ----- dv/tb_value_noise_ground_shade.sv -----
`timescale 1ns / 1ps
// self-checking testbench: streams ground cells through the shade block and checks each alpha
module tb_value_noise_ground_shade;
    import vngs_pkg::*;

    localparam logic [31:0] MUL_X = 32'd374761393;
    localparam logic [31:0] MUL_Y = 32'd668265263;
    localparam logic [31:0] MUL_F = 32'd1274126177;
    localparam logic [63:0] UNIT  = 64'd65536;

    typedef struct packed {
        logic        grass;
        logic [11:0] row;
        logic [11:0] col;
    } t_tile;

    typedef struct {
        t_tile       src;
        logic [7:0]  alpha;
    } t_shade;

    typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} t_rx_mode;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic [2:0]         i_cfg_index   = '0;
    logic [CFG_W-1:0]   i_cfg_data    = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata  = '0;  // cell_x, cell_y
    logic               s_axis_tuser  = 1'b0; // is_grass
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [ALPHA_W-1:0] m_axis_tdata;         // shade_alpha

    // local copy of the register file, at reset values
    logic [15:0] coarse_freq_q   = 16'd2097;
    logic [15:0] fine_freq_q     = 16'd6423;
    logic [31:0] coarse_salt_q   = 32'd7;
    logic [31:0] fine_salt_q     = 32'd23;
    logic [16:0] coarse_weight_q = 17'd43254;
    logic [16:0] threshold_q     = 17'd30147;
    logic [15:0] inv_span_q      = 16'd13653;
    logic [7:0]  max_alpha_q     = 8'd78;

    logic [31:0] next_settings [8];

    t_tile    pending_tiles [$];
    t_shade   shade_due [$];
    t_tile    tile_on_bus;
    int       burst_left     = 0;
    int       gap_left       = 0;
    int       hold_left      = 0;
    logic     hold_armed     = 1'b0;
    int       pattern_left   = 0;
    int       pattern_step   = 0;
    t_rx_mode rx_mode        = RX_OPEN;
    int       mismatch_count = 0;

    value_noise_ground_shade u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [15:0] corner_level(logic [31:0] x, logic [31:0] y,
                                                 logic [31:0] salt);
        logic [31:0] h;
        h = x * MUL_X + y * MUL_Y + salt;
        h = (h ^ (h >> 13)) * MUL_F;
        h = h ^ (h >> 16);
        return h[15:0];
    endfunction

    function automatic logic [63:0] smoothstep(logic [15:0] f);
        logic [63:0] fw;
        logic [63:0] f2;
        fw = f;
        f2 = (fw * fw) >> 16;
        return (f2 * (3 * UNIT - 2 * fw)) >> 16;
    endfunction

    function automatic logic [63:0] lerp16(logic [63:0] a, logic [63:0] b, logic [63:0] s);
        return (a * (UNIT - s) + b * s) >> 16;
    endfunction

    function automatic logic [63:0] octave_level(logic [11:0] cx, logic [11:0] cy,
                                                 logic [15:0] freq, logic [31:0] salt);
        logic [27:0] px;
        logic [27:0] py;
        logic [31:0] x0;
        logic [31:0] y0;
        logic [63:0] sx;
        logic [63:0] sy;
        logic [63:0] top;
        logic [63:0] bottom;
        px = cx * freq;
        py = cy * freq;
        x0 = px[27:16];
        y0 = py[27:16];
        sx = smoothstep(px[15:0]);
        sy = smoothstep(py[15:0]);
        top    = lerp16(corner_level(x0, y0, salt), corner_level(x0 + 1, y0, salt), sx);
        bottom = lerp16(corner_level(x0, y0 + 1, salt), corner_level(x0 + 1, y0 + 1, salt), sx);
        return lerp16(top, bottom, sy);
    endfunction

    function automatic logic [7:0] predict_shade(t_tile t);
        logic [63:0] w;
        logic [63:0] nc;
        logic [63:0] nf;
        logic [63:0] level;
        logic [63:0] ramp;
        logic [63:0] alpha;
        if (!t.grass) return '0;
        w  = (coarse_weight_q > 17'h10000) ? UNIT : 64'(coarse_weight_q);
        nc = octave_level(t.col, t.row, coarse_freq_q, coarse_salt_q);
        nf = octave_level(t.col, t.row, fine_freq_q, fine_salt_q);
        level = (nc * w + nf * (UNIT - w)) >> 16;
        if (level <= threshold_q) return '0;
        ramp = ((level - threshold_q) * inv_span_q) >> 12;
        if (ramp > UNIT) ramp = UNIT;
        alpha = (max_alpha_q * ramp) >> 16;
        return alpha[7:0];
    endfunction

    task automatic report_mismatch(string what, t_tile src, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: x=%0d y=%0d grass=%0b got %0d want %0d",
                 what, src.col, src.row, src.grass, got, want);
        mismatch_count++;
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            REG_COARSE_FREQ: coarse_freq_q   = value[15:0];
            REG_FINE_FREQ:   fine_freq_q     = value[15:0];
            REG_COARSE_SALT: coarse_salt_q   = value;
            REG_FINE_SALT:   fine_salt_q     = value;
            REG_COARSE_WGT:  coarse_weight_q = value[16:0];
            REG_THRESHOLD:   threshold_q     = value[16:0];
            REG_INV_SPAN:    inv_span_q      = value[15:0];
            REG_MAX_ALPHA:   max_alpha_q     = value[7:0];
            default: ;
        endcase
    endtask

    task automatic load_settings();
        for (int i = 0; i < 8; i++) begin
            write_reg(t_reg_idx'(i), next_settings[i]);
        end
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic push_tile(int col, int row, bit grass);
        t_tile t;
        t.col   = 12'(col);
        t.row   = 12'(row);
        t.grass = grass;
        pending_tiles = {pending_tiles, t};
    endtask

    task automatic queue_random_tiles(int n);
        t_tile t;
        repeat (n) begin
            t.col   = ($urandom_range(0, 7) == 0) ? {12{$urandom_range(0, 1) == 1}}
                                                 : 12'($urandom_range(0, 4095));
            t.row   = ($urandom_range(0, 7) == 0) ? {12{$urandom_range(0, 1) == 1}}
                                                 : 12'($urandom_range(0, 4095));
            t.grass = ($urandom_range(0, 4) != 0);
            pending_tiles = {pending_tiles, t};
        end
    endtask

    // sender idle until every shade is back, then let the pipeline settle
    task automatic await_idle();
        int waited;
        waited = 0;
        @(negedge i_clk);
        while ((pending_tiles.size() != 0 || s_axis_tvalid || shade_due.size() != 0)
               && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        if (shade_due.size() != 0) begin
            report_mismatch("shades never returned", shade_due[0].src, shade_due.size(), 0);
            shade_due.delete();
        end
        repeat (20) @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_shade due;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                due.src   = tile_on_bus;
                due.alpha = predict_shade(tile_on_bus);
                shade_due = {shade_due, due};
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_tiles.size() != 0) begin
                    tile_on_bus = pending_tiles.pop_front();
                    s_axis_tdata  <= {tile_on_bus.row, tile_on_bus.col};
                    s_axis_tuser  <= tile_on_bus.grass;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_armed) begin
            hold_armed = 1'b0;
            hold_left  = 150;
            m_axis_tready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 3));
                pattern_left = $urandom_range(8, 64);
            end
            pattern_left--;
            pattern_step++;
            case (rx_mode)
                RX_OPEN:     m_axis_tready <= 1'b1;
                RX_COIN:     m_axis_tready <= ($urandom_range(0, 1) == 1);
                RX_PERIODIC: m_axis_tready <= (pattern_step % 5 != 0);
                default:     m_axis_tready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_shade want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (shade_due.size() == 0) begin
                report_mismatch("shade with no request waiting", '0, m_axis_tdata, 0);
            end else begin
                want = shade_due.pop_front();
                if (m_axis_tdata !== want.alpha) begin
                    report_mismatch("shade_alpha", want.src, m_axis_tdata, want.alpha);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: coordinate extremes and non-grass
        push_tile(0, 0, 1);
        push_tile(4095, 4095, 1);
        push_tile(0, 4095, 1);
        push_tile(4095, 0, 1);
        push_tile(4095, 4095, 0);
        push_tile(0, 0, 0);
        push_tile(1, 1, 1);
        push_tile(2048, 2048, 1);
        push_tile(12'hAAA, 12'h555, 1);
        push_tile(12'h555, 12'hAAA, 1);
        push_tile(4095, 1, 0);
        push_tile(100, 3000, 1);
        queue_random_tiles(70);
        await_idle();

        // zero frequency, weight above one, ramp overflow
        next_settings = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'h0001_FFFF, 32'd0, 32'h0000_FFFF, 32'h0000_00FF};
        load_settings();
        queue_random_tiles(60);
        await_idle();

        // fastest lattice, fine octave only, long output hold-off
        next_settings = '{32'hFFFF, 32'hFFFF, 32'd0, 32'd0,
                          32'd0, 32'd0, 32'h1000, 32'hFF};
        load_settings();
        queue_random_tiles(80);
        hold_armed = 1'b1;
        await_idle();

        // weight and threshold exactly one
        next_settings = '{32'hFFFF, 32'd1, 32'h1234_5678, 32'h9ABC_DEF0,
                          32'h1_0000, 32'h1_0000, 32'hFFFF, 32'd200};
        load_settings();
        queue_random_tiles(40);
        await_idle();

        // threshold above one
        next_settings = '{32'd777, 32'd4321, $urandom, $urandom,
                          32'd30000, 32'h1_FFFF, 32'hFFFF, 32'hFF};
        load_settings();
        queue_random_tiles(30);
        await_idle();

        // zero alpha ceiling with a wide open ramp
        next_settings = '{32'd2097, 32'd6423, $urandom, $urandom,
                          32'd43254, 32'd0, 32'hFFFF, 32'hFFFF_FF00};
        load_settings();
        queue_random_tiles(30);
        await_idle();

        repeat (4) begin
            next_settings[REG_COARSE_FREQ] = $urandom;
            next_settings[REG_FINE_FREQ]   = $urandom;
            next_settings[REG_COARSE_SALT] = $urandom;
            next_settings[REG_FINE_SALT]   = $urandom;
            next_settings[REG_COARSE_WGT]  = ($urandom & 32'hFFFE_0000) | $urandom_range(0, 65536);
            next_settings[REG_THRESHOLD]   = ($urandom & 32'hFFFE_0000)
                                             | $urandom_range(16000, 50000);
            next_settings[REG_INV_SPAN]    = $urandom;
            next_settings[REG_MAX_ALPHA]   = $urandom;
            load_settings();
            queue_random_tiles(85);
            await_idle();
        end

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- value_noise_ground_shade.f -----
+incdir+hw/rtl
hw/rtl/vngs_pkg.sv
hw/rtl/vngs_octave.sv
hw/rtl/value_noise_ground_shade.sv
dv/tb_value_noise_ground_shade.sv
